>>> hw/rtl/cop_pkg.sv
// ----------------------------------------------------------------------------
// Circle overlap package
// Widths and sideband types shared by the circle overlap pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cop_pkg;

    localparam int unsigned IN_W   = 24;   // centre coordinate
    localparam int unsigned RAD_W  = 23;   // radius
    localparam int unsigned DIFF_W = 25;   // centre difference
    localparam int unsigned MAG_W  = 24;   // difference magnitude, radius sum
    localparam int unsigned SQ_W   = 48;   // one squared component
    localparam int unsigned SUM_W  = 49;   // squared distance
    localparam int unsigned ROOT_W = 25;   // distance
    localparam int unsigned QUO_W  = 24;   // push magnitude
    localparam int unsigned PUSH_W = 25;   // signed push component

    localparam int unsigned S_DATA_W = 144;
    localparam int unsigned M_DATA_W = 56;

    // carried alongside the square root
    typedef struct packed {
        logic [MAG_W-1:0] ux;
        logic [MAG_W-1:0] uy;
        logic             pos_x;
        logic             pos_y;
        logic             zero;
        logic [MAG_W-1:0] rsum;
    } t_pre;

    // carried alongside the divider
    typedef struct packed {
        logic             hit;
        logic             pos_x;
        logic             pos_y;
        logic             zero;
        logic [MAG_W-1:0] rsum;
    } t_post;

endpackage

`default_nettype wire

>>> hw/rtl/cop_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, floor result, sideband travels with each item.
// ----------------------------------------------------------------------------
`default_nettype none

module cop_sqrt #(
    parameter int unsigned ROOT_W = 25,
    parameter int unsigned SIDE_W = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_vld,
    input  wire logic [2*ROOT_W-1:0]   i_rad,
    input  wire logic [SIDE_W-1:0]     i_side,
    output logic                       o_vld,
    output logic [ROOT_W-1:0]          o_root,
    output logic [SIDE_W-1:0]          o_side
);

    localparam int unsigned RADW = 2 * ROOT_W;
    localparam int unsigned REMW = ROOT_W + 3;

    logic              r_vld  [1:ROOT_W];
    logic [RADW-1:0]   r_rad  [1:ROOT_W];
    logic [REMW-1:0]   r_rem  [1:ROOT_W];
    logic [ROOT_W-1:0] r_root [1:ROOT_W];
    logic [SIDE_W-1:0] r_side [1:ROOT_W];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_step
            logic              c_vld;
            logic [RADW-1:0]   c_rad;
            logic [REMW-1:0]   c_rem;
            logic [ROOT_W-1:0] c_root;
            logic [SIDE_W-1:0] c_side;
            logic [REMW-1:0]   brought;
            logic [REMW-1:0]   trial;
            logic [REMW-1:0]   n_rem;
            logic [ROOT_W-1:0] n_root;

            if (k == 0) begin : g_first
                assign c_vld  = i_vld;
                assign c_rad  = i_rad;
                assign c_rem  = '0;
                assign c_root = '0;
                assign c_side = i_side;
            end else begin : g_next
                assign c_vld  = r_vld[k];
                assign c_rad  = r_rad[k];
                assign c_rem  = r_rem[k];
                assign c_root = r_root[k];
                assign c_side = r_side[k];
            end

            // bring down the next two radicand bits and try root*4+1
            assign brought = {c_rem[REMW-3:0], c_rad[RADW-1 -: 2]};
            assign trial   = {1'b0, c_root, 2'b01};

            always_comb begin
                if (brought >= trial) begin
                    n_rem  = brought - trial;
                    n_root = {c_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = brought;
                    n_root = {c_root[ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k+1] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k+1] <= c_vld;
                end
                if (i_en) begin
                    r_rad[k+1]  <= {c_rad[RADW-3:0], 2'b00};
                    r_rem[k+1]  <= n_rem;
                    r_root[k+1] <= n_root;
                    r_side[k+1] <= c_side;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[ROOT_W];
    assign o_root = r_root[ROOT_W];
    assign o_side = r_side[ROOT_W];

endmodule

`default_nettype wire

>>> hw/rtl/cop_div.sv
// ----------------------------------------------------------------------------
// Pipelined two-lane divider
// Restoring division, one quotient bit per stage, shared divisor per item.
// The quotient must fit QUO_W bits (upper numerator part below divisor).
// ----------------------------------------------------------------------------
`default_nettype none

module cop_div #(
    parameter int unsigned QUO_W  = 24,
    parameter int unsigned DEN_W  = 25,
    parameter int unsigned SIDE_W = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_vld,
    input  wire logic [QUO_W+DEN_W-2:0]      i_num_x,
    input  wire logic [QUO_W+DEN_W-2:0]      i_num_y,
    input  wire logic [DEN_W-1:0]            i_den,
    input  wire logic [SIDE_W-1:0]           i_side,
    output logic                             o_vld,
    output logic [QUO_W-1:0]                 o_quo_x,
    output logic [QUO_W-1:0]                 o_quo_y,
    output logic [SIDE_W-1:0]                o_side
);

    localparam int unsigned NUM_W = QUO_W + DEN_W - 1;

    logic              r_vld  [1:QUO_W];
    logic [DEN_W-1:0]  r_den  [1:QUO_W];
    logic [SIDE_W-1:0] r_side [1:QUO_W];
    logic [DEN_W-1:0]  r_rem  [0:1][1:QUO_W];
    logic [QUO_W-1:0]  r_lo   [0:1][1:QUO_W];
    logic [QUO_W-1:0]  r_quo  [0:1][1:QUO_W];

    genvar k, l;
    generate
        for (k = 0; k < QUO_W; k++) begin : g_step
            logic              c_vld;
            logic [DEN_W-1:0]  c_den;
            logic [SIDE_W-1:0] c_side;

            if (k == 0) begin : g_first
                assign c_vld  = i_vld;
                assign c_den  = i_den;
                assign c_side = i_side;
            end else begin : g_next
                assign c_vld  = r_vld[k];
                assign c_den  = r_den[k];
                assign c_side = r_side[k];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k+1] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k+1] <= c_vld;
                end
                if (i_en) begin
                    r_den[k+1]  <= c_den;
                    r_side[k+1] <= c_side;
                end
            end

            for (l = 0; l < 2; l++) begin : g_lane
                logic [DEN_W-1:0] c_rem;
                logic [QUO_W-1:0] c_lo;
                logic [QUO_W-1:0] c_quo;
                logic [DEN_W:0]   brought;
                logic [DEN_W:0]   diff;
                logic             take;

                if (k == 0) begin : g_first
                    logic [NUM_W-1:0] num;
                    assign num   = (l == 0) ? i_num_x : i_num_y;
                    assign c_rem = {1'b0, num[NUM_W-1:QUO_W]};
                    assign c_lo  = num[QUO_W-1:0];
                    assign c_quo = '0;
                end else begin : g_next
                    assign c_rem = r_rem[l][k];
                    assign c_lo  = r_lo[l][k];
                    assign c_quo = r_quo[l][k];
                end

                assign brought = {c_rem, c_lo[QUO_W-1]};
                assign diff    = brought - {1'b0, c_den};
                assign take    = (brought >= {1'b0, c_den});

                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[l][k+1] <= take ? diff[DEN_W-1:0] : brought[DEN_W-1:0];
                        r_lo[l][k+1]  <= {c_lo[QUO_W-2:0], 1'b0};
                        r_quo[l][k+1] <= {c_quo[QUO_W-2:0], take};
                    end
                end
            end
        end
    endgenerate

    assign o_vld   = r_vld[QUO_W];
    assign o_quo_x = r_quo[0][QUO_W];
    assign o_quo_y = r_quo[1][QUO_W];
    assign o_side  = r_side[QUO_W];

endmodule

`default_nettype wire

>>> hw/rtl/circle_overlap_penetration_top.sv
// ----------------------------------------------------------------------------
// Circle overlap with penetration vector
// Tests two circles for overlap and returns the push that separates them.
// ----------------------------------------------------------------------------
// One circle pair enters per clock unless the output stalls. Its result
// passes the difference, magnitude, squaring and sum registers, the square
// root (one root bit per stage), the compare and multiply stages, the
// division (one quotient bit per stage) and the output register. The whole
// pipeline holds while a result beat waits on the output; otherwise a beat
// is taken every cycle. Values are fixed point with 8 fraction bits; the
// distance and the push both truncate. A point test is radius_b = 0.
`default_nettype none

module circle_overlap_penetration_top
    import cop_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // centre_a_x, centre_a_y, radius_a, centre_b_x, centre_b_y, radius_b, pad
    input  wire logic [S_DATA_W-1:0]   i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // push_x, push_y, pad
    output logic [M_DATA_W-1:0]        o_m_axis_tdata,
    // hit
    output logic                       o_m_axis_tuser
);

    logic en;

    logic signed [IN_W-1:0] ax, ay, bx, by;
    logic [RAD_W-1:0]       ra, rb;

    assign ax = i_s_axis_tdata[23:0];
    assign ay = i_s_axis_tdata[47:24];
    assign ra = i_s_axis_tdata[70:48];
    assign bx = i_s_axis_tdata[94:71];
    assign by = i_s_axis_tdata[118:95];
    assign rb = i_s_axis_tdata[141:119];

    logic r_out_vld;
    assign en = !r_out_vld || i_m_axis_tready;
    // take no beat while reset holds the valid bits low
    assign o_s_axis_tready = en && i_rst_n;

    // difference
    logic                     r_a_vld;
    logic signed [DIFF_W-1:0] r_a_dx, r_a_dy;
    logic [MAG_W-1:0]         r_a_rsum;

    // magnitude
    logic r_b_vld;
    t_pre r_b_side;

    // squares
    logic            r_c_vld;
    logic [SQ_W-1:0] r_c_sqx, r_c_sqy;
    t_pre            r_c_side;

    // sum
    logic             r_d_vld;
    logic [SUM_W-1:0] r_d_sum;
    t_pre             r_d_side;

    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    logic [$bits(t_pre)-1:0] sq_side_bits;
    t_pre              sq_side;

    // compare
    logic              r_e_vld;
    logic              r_e_hit;
    logic [MAG_W-1:0]  r_e_def;
    logic [ROOT_W-1:0] r_e_len;
    t_pre              r_e_side;

    // multiply
    logic              r_f_vld;
    logic [SQ_W-1:0]   r_f_px, r_f_py;
    logic [ROOT_W-1:0] r_f_len;
    t_post             r_f_side;

    logic              dv_vld;
    logic [QUO_W-1:0]  dv_qx, dv_qy;
    logic [$bits(t_post)-1:0] dv_side_bits;
    t_post             dv_side;

    logic [PUSH_W-1:0] r_out_px, r_out_py;
    logic              r_out_hit;
    logic [PUSH_W-1:0] n_px, n_py;

    logic [DIFF_W-1:0] dx_c, dy_c;
    logic [DIFF_W-1:0] ux_c, uy_c;

    assign dx_c = r_a_dx;
    assign dy_c = r_a_dy;
    assign ux_c = r_a_dx[DIFF_W-1] ? (~dx_c + 1'b1) : dx_c;
    assign uy_c = r_a_dy[DIFF_W-1] ? (~dy_c + 1'b1) : dy_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_e_vld   <= 1'b0;
            r_f_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_a_vld   <= i_s_axis_tvalid;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_d_vld   <= r_c_vld;
            r_e_vld   <= sq_vld;
            r_f_vld   <= r_e_vld;
            r_out_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dx   <= DIFF_W'(bx) - DIFF_W'(ax);
            r_a_dy   <= DIFF_W'(by) - DIFF_W'(ay);
            r_a_rsum <= MAG_W'(ra) + MAG_W'(rb);

            r_b_side.ux    <= ux_c[MAG_W-1:0];
            r_b_side.uy    <= uy_c[MAG_W-1:0];
            r_b_side.pos_x <= !r_a_dx[DIFF_W-1] && (r_a_dx != '0);
            r_b_side.pos_y <= !r_a_dy[DIFF_W-1] && (r_a_dy != '0);
            r_b_side.zero  <= (r_a_dx == '0) && (r_a_dy == '0);
            r_b_side.rsum  <= r_a_rsum;

            r_c_sqx  <= r_b_side.ux * r_b_side.ux;
            r_c_sqy  <= r_b_side.uy * r_b_side.uy;
            r_c_side <= r_b_side;

            r_d_sum  <= SUM_W'(r_c_sqx) + SUM_W'(r_c_sqy);
            r_d_side <= r_c_side;

            r_e_hit  <= sq_root < ROOT_W'(sq_side.rsum);
            r_e_def  <= sq_side.rsum - sq_root[MAG_W-1:0];
            r_e_len  <= sq_root;
            r_e_side <= sq_side;

            r_f_px         <= r_e_side.ux * r_e_def;
            r_f_py         <= r_e_side.uy * r_e_def;
            r_f_len        <= r_e_len;
            r_f_side.hit   <= r_e_hit;
            r_f_side.pos_x <= r_e_side.pos_x;
            r_f_side.pos_y <= r_e_side.pos_y;
            r_f_side.zero  <= r_e_side.zero;
            r_f_side.rsum  <= r_e_side.rsum;

            r_out_hit <= dv_side.hit;
            r_out_px  <= n_px;
            r_out_py  <= n_py;
        end
    end

    cop_sqrt #(
        .ROOT_W (ROOT_W),
        .SIDE_W ($bits(t_pre))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_d_vld),
        .i_rad   ({{(2*ROOT_W-SUM_W){1'b0}}, r_d_sum}),
        .i_side  (r_d_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side_bits)
    );
    assign sq_side = t_pre'(sq_side_bits);

    cop_div #(
        .QUO_W  (QUO_W),
        .DEN_W  (ROOT_W),
        .SIDE_W ($bits(t_post))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_f_vld),
        .i_num_x (r_f_px),
        .i_num_y (r_f_py),
        .i_den   (r_f_len),
        .i_side  (r_f_side),
        .o_vld   (dv_vld),
        .o_quo_x (dv_qx),
        .o_quo_y (dv_qy),
        .o_side  (dv_side_bits)
    );
    assign dv_side = t_post'(dv_side_bits);

    // push points against the displacement; coincident centres push along -x
    always_comb begin
        if (!dv_side.hit) begin
            n_px = '0;
            n_py = '0;
        end else if (dv_side.zero) begin
            n_px = '0 - PUSH_W'(dv_side.rsum);
            n_py = '0;
        end else begin
            n_px = dv_side.pos_x ? ('0 - PUSH_W'(dv_qx)) : PUSH_W'(dv_qx);
            n_py = dv_side.pos_y ? ('0 - PUSH_W'(dv_qy)) : PUSH_W'(dv_qy);
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_out_hit;
    assign o_m_axis_tdata  = {{(M_DATA_W-2*PUSH_W){1'b0}}, r_out_py, r_out_px};

    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("push not zero on a miss");

    a_hit_deficit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_vld && r_e_hit |-> r_e_def != '0)
        else $error("hit with zero penetration depth");

    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_vld && en |=> o_m_axis_tvalid)
        else $error("divider result lost before output");

endmodule

`default_nettype wire
